// File: hdl/obcc_pkg.sv
// types, constants and helpers shared by the oriented box clip classifier
package obcc_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned SIDE_W     = 31;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned HALF_W     = 31;
  localparam int unsigned OFF_W      = 32;
  localparam int unsigned ROT_W      = 48;
  localparam int unsigned HXY_W      = 62;
  localparam int unsigned HZV_W      = 33;
  localparam int unsigned VIEW_W     = 2;
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  // coefficient times zero-extended side length
  localparam int unsigned SPROD_W    = SIDE_W + 1 + COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_X       = 3'd0,
    CFG_ROT_Y       = 3'd1,
    CFG_ROT_Z       = 3'd2,
    CFG_OFF_X       = 3'd3,
    CFG_OFF_Y       = 3'd4,
    CFG_OFF_Z       = 3'd5,
    CFG_HALF_XY     = 3'd6,
    CFG_HALF_Z_VIEW = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REGION_OUTSIDE = 2'd0,
    REGION_PARTIAL = 2'd1,
    REGION_INSIDE  = 2'd2
  } region_e;

  typedef enum logic [1:0] {
    DEC_NO        = 2'd0,
    DEC_PARTIALLY = 2'd1,
    DEC_YES       = 2'd2
  } decision_e;

  typedef enum logic [VIEW_W-1:0] {
    VIEW_INTERIOR = 2'd0,
    VIEW_EXTERIOR = 2'd1,
    VIEW_RAMP     = 2'd2
  } view_e;

  // decoded box configuration as seen by the datapath
  typedef struct packed {
    logic [NUM_AXES-1:0][NUM_AXES-1:0][COEF_W-1:0] coef;
    logic [NUM_AXES-1:0][OFF_W-1:0]                offset;
    logic [NUM_AXES-1:0][HALF_W-1:0]               half;
    logic [VIEW_W-1:0]                             view;
  } cfg_t;

  // per-stage handshake: upstream word present, stage may load
  typedef struct packed {
    logic valid;
    logic load;
  } stage_ctl_t;

  // width of a coordinate after sign extension from the coordinate width
  function automatic int unsigned pos_w(int unsigned cw);
    return (cw > POS_W) ? POS_W + 1 : cw;
  endfunction

  // width of the accumulated local bounds
  function automatic int unsigned sum_w(int unsigned cw);
    int unsigned pw;
    pw = pos_w(cw) + COEF_W;
    return ((pw > SPROD_W) ? pw : SPROD_W) + 3;
  endfunction

  // decision row of the view; unused view code behaves as interior
  function automatic decision_e map_decision(logic [VIEW_W-1:0] view, region_e region);
    decision_e dec;
    case (view)
      VIEW_EXTERIOR: begin
        case (region)
          REGION_INSIDE:  dec = DEC_NO;
          REGION_PARTIAL: dec = DEC_PARTIALLY;
          default:        dec = DEC_YES;
        endcase
      end
      default: begin
        case (region)
          REGION_INSIDE:  dec = DEC_YES;
          REGION_PARTIAL: dec = DEC_PARTIALLY;
          default:        dec = DEC_NO;
        endcase
      end
    endcase
    return dec;
  endfunction

endpackage

// File: hdl/obcc_if.sv
// handshake interfaces for the input, result and configuration channels

interface obcc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [obcc_pkg::POS_W-1:0]        pos_x;
  logic [obcc_pkg::POS_W-1:0]        pos_y;
  logic [obcc_pkg::POS_W-1:0]        pos_z;
  logic [obcc_pkg::SIDE_W-1:0]       side;
  modport source (output valid, mode, pos_x, pos_y, pos_z, side, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, pos_z, side, output ready);
endinterface

interface obcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] region;
  logic [1:0] decision;
  modport source (output valid, region, decision, input ready);
  modport sink   (input valid, region, decision, output ready);
endinterface

interface obcc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [obcc_pkg::CFG_IDX_W-1:0]    index;
  logic [obcc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/oriented_box_clip_classifier_unit.sv
// Oriented box clip classifier: takes one point or axis-aligned cube word per clock while
// in_i.ready is high and returns one region/decision word per input, in order. Each word
// runs through three register stages (rotation products, per-axis accumulation of centre
// and cube bounds, face compare with the view decision row), and the result is registered
// in the last of them. The sustained rate is one word per cycle while the output is ready.
// Each stage holds its word under back-pressure and loads again as soon as the stage after
// it moves. The configuration port always accepts, and a write takes effect at once in
// every stage that reads it; write it only while no word is in flight.
// COORD_WIDTH sets the bit from which positions and offsets are sign-extended.
module oriented_box_clip_classifier_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  obcc_cfg_if.sink    cfg_i,
  obcc_in_if.sink     in_i,
  obcc_out_if.source  out_o
);

  localparam int unsigned PW  = obcc_pkg::pos_w(COORD_WIDTH);
  localparam int unsigned PPW = PW + obcc_pkg::COEF_W;
  localparam int unsigned SW  = obcc_pkg::sum_w(COORD_WIDTH);

  logic [obcc_pkg::ROT_W-1:0]  rot_q [3];
  logic [obcc_pkg::OFF_W-1:0]  off_q [3];
  logic [obcc_pkg::HXY_W-1:0]  hxy_q;
  logic [obcc_pkg::HZV_W-1:0]  hzv_q;
  obcc_pkg::cfg_t              cfg;

  obcc_pkg::stage_ctl_t        ctl1, ctl2, ctl3;
  logic                        v1, v2, v3;
  logic                        rdy1, rdy2, rdy3;
  logic                        mode1, mode2;
  logic signed [PPW-1:0]       prod [3][3];
  logic signed [obcc_pkg::SPROD_W-1:0] sprod [3][3];
  logic signed [SW-1:0]        lo [3];
  logic signed [SW-1:0]        hi [3];
  obcc_pkg::region_e           region;
  obcc_pkg::decision_e         decision;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        rot_q[i] <= '0;
        off_q[i] <= '0;
      end
      hxy_q <= '0;
      hzv_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (obcc_pkg::cfg_reg_e'(cfg_i.index))
        obcc_pkg::CFG_ROT_X:       rot_q[0] <= cfg_i.data[obcc_pkg::ROT_W-1:0];
        obcc_pkg::CFG_ROT_Y:       rot_q[1] <= cfg_i.data[obcc_pkg::ROT_W-1:0];
        obcc_pkg::CFG_ROT_Z:       rot_q[2] <= cfg_i.data[obcc_pkg::ROT_W-1:0];
        obcc_pkg::CFG_OFF_X:       off_q[0] <= cfg_i.data[obcc_pkg::OFF_W-1:0];
        obcc_pkg::CFG_OFF_Y:       off_q[1] <= cfg_i.data[obcc_pkg::OFF_W-1:0];
        obcc_pkg::CFG_OFF_Z:       off_q[2] <= cfg_i.data[obcc_pkg::OFF_W-1:0];
        obcc_pkg::CFG_HALF_XY:     hxy_q    <= cfg_i.data[obcc_pkg::HXY_W-1:0];
        obcc_pkg::CFG_HALF_Z_VIEW: hzv_q    <= cfg_i.data[obcc_pkg::HZV_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack the register fields
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cfg.coef[i][j] = rot_q[i][obcc_pkg::COEF_W*j +: obcc_pkg::COEF_W];
      end
      cfg.offset[i] = off_q[i];
    end
    cfg.half[0] = hxy_q[obcc_pkg::HALF_W-1:0];
    cfg.half[1] = hxy_q[2*obcc_pkg::HALF_W-1:obcc_pkg::HALF_W];
    cfg.half[2] = hzv_q[obcc_pkg::HALF_W-1:0];
    cfg.view    = hzv_q[obcc_pkg::HALF_W +: obcc_pkg::VIEW_W];
  end

  // stall chain: a stage loads when empty or when the next one moves
  assign rdy3 = out_o.ready | ~v3;
  assign rdy2 = rdy3 | ~v2;
  assign rdy1 = rdy2 | ~v1;
  assign in_i.ready = rdy1;

  assign ctl1 = '{valid: in_i.valid, load: rdy1};
  assign ctl2 = '{valid: v1, load: rdy2};
  assign ctl3 = '{valid: v2, load: rdy3};

  obcc_mul #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl1),
    .cfg_i   (cfg),
    .mode_i  (in_i.mode),
    .pos_x_i (in_i.pos_x),
    .pos_y_i (in_i.pos_y),
    .pos_z_i (in_i.pos_z),
    .side_i  (in_i.side),
    .valid_o (v1),
    .mode_o  (mode1),
    .prod_o  (prod),
    .sprod_o (sprod)
  );

  obcc_accum #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl2),
    .cfg_i   (cfg),
    .mode_i  (mode1),
    .prod_i  (prod),
    .sprod_i (sprod),
    .valid_o (v2),
    .mode_o  (mode2),
    .lo_o    (lo),
    .hi_o    (hi)
  );

  obcc_classify #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl3),
    .cfg_i      (cfg),
    .mode_i     (mode2),
    .lo_i       (lo),
    .hi_i       (hi),
    .valid_o    (v3),
    .region_o   (region),
    .decision_o (decision)
  );

  assign out_o.valid    = v3;
  assign out_o.region   = region;
  assign out_o.decision = decision;

endmodule

// File: hdl/obcc_mul.sv
// first pipeline stage: rotation products of position and side length
module obcc_mul #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  obcc_pkg::stage_ctl_t              ctl_i,
  input  obcc_pkg::cfg_t                    cfg_i,
  input  logic                              mode_i,
  input  logic [obcc_pkg::POS_W-1:0]        pos_x_i,
  input  logic [obcc_pkg::POS_W-1:0]        pos_y_i,
  input  logic [obcc_pkg::POS_W-1:0]        pos_z_i,
  input  logic [obcc_pkg::SIDE_W-1:0]       side_i,
  output logic                              valid_o,
  output logic                              mode_o,
  output logic signed [obcc_pkg::pos_w(COORD_WIDTH)+obcc_pkg::COEF_W-1:0] prod_o [3][3],
  output logic signed [obcc_pkg::SPROD_W-1:0] sprod_o [3][3]
);

  localparam int unsigned PW  = obcc_pkg::pos_w(COORD_WIDTH);
  localparam int unsigned PPW = PW + obcc_pkg::COEF_W;

  logic [obcc_pkg::POS_W-1:0]          pos [3];
  logic signed [PW-1:0]                p [3];
  logic signed [obcc_pkg::SIDE_W:0]    side_s;
  logic signed [PPW-1:0]               prod_d [3][3];
  logic signed [obcc_pkg::SPROD_W-1:0] sprod_d [3][3];
  logic signed [PPW-1:0]               prod_q [3][3];
  logic signed [obcc_pkg::SPROD_W-1:0] sprod_q [3][3];
  logic                                valid_q;
  logic                                mode_q;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  // sign extension from the coordinate width
  for (genvar j = 0; j < 3; j++) begin : g_ext
    assign p[j] = PW'($signed(COORD_WIDTH'(pos[j])));
  end

  assign side_s = $signed({1'b0, side_i});

  // nine position products and nine side products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j]  = $signed(cfg_i.coef[i][j]) * p[j];
        sprod_d[i][j] = $signed(cfg_i.coef[i][j]) * side_s;
      end
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= ctl_i.valid;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mode_q  <= mode_i;
      prod_q  <= prod_d;
      sprod_q <= sprod_d;
    end
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  assign prod_o  = prod_q;
  assign sprod_o = sprod_q;

endmodule

// File: hdl/obcc_accum.sv
// second pipeline stage: local coordinate and cube bounds per axis
module obcc_accum #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  obcc_pkg::stage_ctl_t              ctl_i,
  input  obcc_pkg::cfg_t                    cfg_i,
  input  logic                              mode_i,
  input  logic signed [obcc_pkg::pos_w(COORD_WIDTH)+obcc_pkg::COEF_W-1:0] prod_i [3][3],
  input  logic signed [obcc_pkg::SPROD_W-1:0] sprod_i [3][3],
  output logic                              valid_o,
  output logic                              mode_o,
  output logic signed [obcc_pkg::sum_w(COORD_WIDTH)-1:0] lo_o [3],
  output logic signed [obcc_pkg::sum_w(COORD_WIDTH)-1:0] hi_o [3]
);

  localparam int unsigned PW = obcc_pkg::pos_w(COORD_WIDTH);
  localparam int unsigned SW = obcc_pkg::sum_w(COORD_WIDTH);

  logic signed [PW-1:0] off_s [3];
  logic signed [SW-1:0] base [3];
  logic signed [SW-1:0] up [3];
  logic signed [SW-1:0] dn [3];
  logic signed [SW-1:0] lo_d [3];
  logic signed [SW-1:0] hi_d [3];
  logic signed [SW-1:0] lo_q [3];
  logic signed [SW-1:0] hi_q [3];
  logic                 valid_q;
  logic                 mode_q;

  for (genvar i = 0; i < 3; i++) begin : g_off
    assign off_s[i] = PW'($signed(COORD_WIDTH'(cfg_i.offset[i])));
  end

  // translated centre plus positive and negative side spans
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      base[i] = (SW'(off_s[i]) <<< obcc_pkg::FRAC_SHIFT)
              + SW'(prod_i[i][0]) + SW'(prod_i[i][1]) + SW'(prod_i[i][2]);
      up[i] = '0;
      dn[i] = '0;
      for (int j = 0; j < 3; j++) begin
        if (mode_i) begin
          if (sprod_i[i][j] > 0) begin
            up[i] = up[i] + SW'(sprod_i[i][j]);
          end else begin
            dn[i] = dn[i] + SW'(sprod_i[i][j]);
          end
        end
      end
      hi_d[i] = base[i] + up[i];
      lo_d[i] = base[i] + dn[i];
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= ctl_i.valid;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mode_q <= mode_i;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
    end
  end

  assign valid_o = valid_q;
  assign mode_o  = mode_q;
  assign lo_o    = lo_q;
  assign hi_o    = hi_q;

endmodule

// File: hdl/obcc_classify.sv
// third pipeline stage: bound compare, region and view decision, output register
module obcc_classify #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  obcc_pkg::stage_ctl_t              ctl_i,
  input  obcc_pkg::cfg_t                    cfg_i,
  input  logic                              mode_i,
  input  logic signed [obcc_pkg::sum_w(COORD_WIDTH)-1:0] lo_i [3],
  input  logic signed [obcc_pkg::sum_w(COORD_WIDTH)-1:0] hi_i [3],
  output logic                              valid_o,
  output obcc_pkg::region_e                 region_o,
  output obcc_pkg::decision_e               decision_o
);

  localparam int unsigned SW = obcc_pkg::sum_w(COORD_WIDTH);

  logic signed [SW-1:0]  h [3];
  logic [2:0]            fits;
  logic [2:0]            beyond;
  obcc_pkg::region_e     region_d;
  obcc_pkg::decision_e   decision_d;
  logic                  valid_q;
  logic                  mode_q;
  obcc_pkg::region_e     region_q;
  obcc_pkg::decision_e   decision_q;

  // half extents scaled to the product format, compared on both faces
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h[i]      = $signed(SW'({cfg_i.half[i], {obcc_pkg::FRAC_SHIFT{1'b0}}}));
      fits[i]   = (lo_i[i] >= -h[i]) && (hi_i[i] <= h[i]);
      beyond[i] = (lo_i[i] > h[i]) || (hi_i[i] < -h[i]);
    end
  end

  // region, then the view's decision row
  always_comb begin
    if (&fits) begin
      region_d = obcc_pkg::REGION_INSIDE;
    end else if ((|beyond) || !mode_i) begin
      region_d = obcc_pkg::REGION_OUTSIDE;
    end else begin
      region_d = obcc_pkg::REGION_PARTIAL;
    end
    decision_d = obcc_pkg::map_decision(cfg_i.view, region_d);
  end

  // output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      valid_q <= ctl_i.valid;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mode_q     <= mode_i;
      region_q   <= region_d;
      decision_q <= decision_d;
    end
  end

  assign valid_o    = valid_q;
  assign region_o   = region_q;
  assign decision_o = decision_q;

  // a point has no extent, so it is never partial
  a_point_not_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !mode_q |-> region_q != obcc_pkg::REGION_PARTIAL)
    else $error("point classified as partial");

  // interior, ramp and unused views pass the region through
  a_view_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (cfg_i.view != obcc_pkg::VIEW_EXTERIOR) |->
      2'(decision_q) == 2'(region_q))
    else $error("decision differs from region for direct view");

  // exterior view mirrors the region
  a_view_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (cfg_i.view == obcc_pkg::VIEW_EXTERIOR) |->
      2'(decision_q) == 2'(2'd2 - 2'(region_q)))
    else $error("decision not mirrored for exterior view");

endmodule
